>>> src/prtc_pkg.sv
// Shared types, register map and constants for the RTC register file.
package prtc_pkg;

   // Defaults for the top-level parameters
   localparam int STORE_BYTES_DEF  = 65536;
   localparam int COUNTER_BITS_DEF = 47;
   localparam int MAX_TRANSFER_DEF = 16;

   // Front-to-back queue depth
   localparam int QUEUE_DEPTH = 2;

   localparam int WINDOW_BYTES = 6;
   localparam int ALARM_BYTES  = 4;

   // Configuration port
   localparam int CSR_ADDR_BITS = 5;
   localparam logic [2:0] REG_WINDOW_BASE  = 3'd0;
   localparam logic [2:0] REG_CTRL_ADDR    = 3'd1;
   localparam logic [2:0] REG_EVENT_ADDR   = 3'd2;
   localparam logic [2:0] REG_VALUE_ADDR   = 3'd3;
   localparam logic [2:0] REG_IRQM_ADDR    = 3'd4;
   localparam logic [2:0] REG_ENABLE_MASK  = 3'd5;
   localparam logic [2:0] REG_EVENT_BITS   = 3'd6;

   localparam logic [15:0] WINDOW_BASE_RST = 16'hF802;
   localparam logic [15:0] CTRL_ADDR_RST   = 16'hF800;
   localparam logic [15:0] EVENT_ADDR_RST  = 16'hF80C;
   localparam logic [15:0] VALUE_ADDR_RST  = 16'hF808;
   localparam logic [15:0] IRQM_ADDR_RST   = 16'hF80E;
   localparam logic [7:0]  ENABLE_MASK_RST = 8'h40;
   localparam logic [7:0]  EVENT_BITS_RST  = 8'h01;

   // Request kind codes
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_READ,
      OP_WRITE,
      OP_REJECT,
      OP_NOP
   } op_kind_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_RELOAD,
      BK_RUN,
      BK_FINISH
   } back_state_type;

   typedef struct packed {
      logic [15:0] window_base;
      logic [15:0] ctrl_addr;
      logic [15:0] event_addr;
      logic [15:0] value_addr;
      logic [15:0] irqm_addr;
      logic [7:0]  enable_mask;
      logic [7:0]  event_bits;
   } cfg_type;

   typedef struct packed {
      op_kind_type op;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic        snap_take;
      logic        in_window;
      logic [2:0]  win_ofs;
      logic        alarm_check;
   } entry_type;

endpackage

>>> src/prtc_csr.sv
// APB configuration registers for the RTC register file.
module prtc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [prtc_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready,
   output prtc_pkg::cfg_type                    cfg,
   output logic                                 cfg_wr
);

   prtc_pkg::cfg_type cfg_ff;
   prtc_pkg::cfg_type cfg_in;
   logic [2:0]        reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign cfg_wr  = psel && penable && pwrite;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_wr) begin
         case (reg_idx)
            prtc_pkg::REG_WINDOW_BASE: cfg_in.window_base = pwdata[15:0];
            prtc_pkg::REG_CTRL_ADDR:   cfg_in.ctrl_addr   = pwdata[15:0];
            prtc_pkg::REG_EVENT_ADDR:  cfg_in.event_addr  = pwdata[15:0];
            prtc_pkg::REG_VALUE_ADDR:  cfg_in.value_addr  = pwdata[15:0];
            prtc_pkg::REG_IRQM_ADDR:   cfg_in.irqm_addr   = pwdata[15:0];
            prtc_pkg::REG_ENABLE_MASK: cfg_in.enable_mask = pwdata[7:0];
            prtc_pkg::REG_EVENT_BITS:  cfg_in.event_bits  = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_base <= prtc_pkg::WINDOW_BASE_RST;
         cfg_ff.ctrl_addr   <= prtc_pkg::CTRL_ADDR_RST;
         cfg_ff.event_addr  <= prtc_pkg::EVENT_ADDR_RST;
         cfg_ff.value_addr  <= prtc_pkg::VALUE_ADDR_RST;
         cfg_ff.irqm_addr   <= prtc_pkg::IRQM_ADDR_RST;
         cfg_ff.enable_mask <= prtc_pkg::ENABLE_MASK_RST;
         cfg_ff.event_bits  <= prtc_pkg::EVENT_BITS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         prtc_pkg::REG_WINDOW_BASE: prdata = {16'h0000, cfg_ff.window_base};
         prtc_pkg::REG_CTRL_ADDR:   prdata = {16'h0000, cfg_ff.ctrl_addr};
         prtc_pkg::REG_EVENT_ADDR:  prdata = {16'h0000, cfg_ff.event_addr};
         prtc_pkg::REG_VALUE_ADDR:  prdata = {16'h0000, cfg_ff.value_addr};
         prtc_pkg::REG_IRQM_ADDR:   prdata = {16'h0000, cfg_ff.irqm_addr};
         prtc_pkg::REG_ENABLE_MASK: prdata = {24'h000000, cfg_ff.enable_mask};
         prtc_pkg::REG_EVENT_BITS:  prdata = {24'h000000, cfg_ff.event_bits};
         default:                   prdata = 32'h0000_0000;
      endcase
   end

endmodule

>>> src/prtc_front.sv
// Front end: classifies requests and tracks transfer progress.
module prtc_front #(
   parameter int STORE_BYTES  = prtc_pkg::STORE_BYTES_DEF,
   parameter int MAX_TRANSFER = prtc_pkg::MAX_TRANSFER_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  prtc_pkg::cfg_type   cfg,
   input  logic                accept,
   input  logic [1:0]          req_kind,
   input  logic [15:0]         req_address,
   input  logic                req_first_byte,
   input  logic [4:0]          req_transfer_len,
   input  logic [7:0]          req_write_data,
   output prtc_pkg::entry_type entry
);

   localparam logic [16:0] STORE_LIMIT = 17'(STORE_BYTES);
   localparam logic [4:0]  LEN_MAX     = 5'(MAX_TRANSFER);
   localparam logic [4:0]  SEEN_MAX    = 5'd31;

   logic [15:0] transfer_start_ff, transfer_start_in;
   logic [4:0]  bytes_seen_ff, bytes_seen_in;
   logic        alarm_touched_ff, alarm_touched_in;

   logic [4:0]  len_eff;
   logic [15:0] start_eff;
   logic [4:0]  seen_base, seen_next;
   logic        touched_base, touched_acc;
   logic [16:0] addr17, end17, win_lo, win_hi, val_lo, val_hi;
   logic        reject, is_alarm, last_byte, is_xfer;

   always_comb begin
      if (req_transfer_len == 5'd0) begin
         len_eff = 5'd1;
      end else if (req_transfer_len > LEN_MAX) begin
         len_eff = LEN_MAX;
      end else begin
         len_eff = req_transfer_len;
      end

      start_eff    = req_first_byte ? req_address : transfer_start_ff;
      seen_base    = req_first_byte ? 5'd0 : bytes_seen_ff;
      touched_base = req_first_byte ? 1'b0 : alarm_touched_ff;

      addr17 = {1'b0, req_address};
      end17  = {1'b0, start_eff} + 17'(len_eff);
      reject = (end17 > STORE_LIMIT) || (addr17 >= STORE_LIMIT);

      win_lo = {1'b0, cfg.window_base};
      win_hi = win_lo + 17'(prtc_pkg::WINDOW_BYTES);
      val_lo = {1'b0, cfg.value_addr};
      val_hi = val_lo + 17'(prtc_pkg::ALARM_BYTES);

      is_alarm = (req_address == cfg.ctrl_addr) || (req_address == cfg.event_addr) ||
                 (req_address == cfg.irqm_addr) || ((addr17 >= val_lo) && (addr17 < val_hi));

      seen_next   = (seen_base == SEEN_MAX) ? SEEN_MAX : seen_base + 5'd1;
      touched_acc = touched_base || is_alarm;
      last_byte   = (seen_next == len_eff);
      is_xfer     = (req_kind == prtc_pkg::KIND_READ) || (req_kind == prtc_pkg::KIND_WRITE);

      entry.address     = req_address;
      entry.write_data  = req_write_data;
      entry.in_window   = (addr17 >= win_lo) && (addr17 < win_hi);
      entry.win_ofs     = 3'(req_address - cfg.window_base);
      entry.snap_take   = req_first_byte && (addr17 < win_hi) &&
                          ((addr17 + 17'(len_eff)) > win_lo);
      entry.alarm_check = last_byte && touched_acc;

      case (req_kind)
         prtc_pkg::KIND_TICK:  entry.op = prtc_pkg::OP_TICK;
         prtc_pkg::KIND_READ:  entry.op = reject ? prtc_pkg::OP_REJECT : prtc_pkg::OP_READ;
         prtc_pkg::KIND_WRITE: entry.op = reject ? prtc_pkg::OP_REJECT : prtc_pkg::OP_WRITE;
         default:              entry.op = prtc_pkg::OP_NOP;
      endcase

      transfer_start_in = transfer_start_ff;
      bytes_seen_in     = bytes_seen_ff;
      alarm_touched_in  = alarm_touched_ff;
      if (accept && is_xfer) begin
         transfer_start_in = start_eff;
         bytes_seen_in     = seen_base;
         alarm_touched_in  = touched_base;
         if (!reject) begin
            bytes_seen_in = seen_next;
            // Drop the touched flag once the last write byte has run the check
            if (req_kind == prtc_pkg::KIND_WRITE) begin
               alarm_touched_in = last_byte ? 1'b0 : touched_acc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         transfer_start_ff <= '0;
         bytes_seen_ff     <= '0;
         alarm_touched_ff  <= 1'b0;
      end else begin
         transfer_start_ff <= transfer_start_in;
         bytes_seen_ff     <= bytes_seen_in;
         alarm_touched_ff  <= alarm_touched_in;
      end
   end

endmodule

>>> src/prtc_queue.sv
// Short FIFO between the front end and the back end.
module prtc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  prtc_pkg::entry_type push_entry,
   input  logic                pop,
   output logic                valid,
   output logic                full,
   output prtc_pkg::entry_type head
);

   localparam int PTR_W = (prtc_pkg::QUEUE_DEPTH > 1) ? $clog2(prtc_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(prtc_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(prtc_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(prtc_pkg::QUEUE_DEPTH);

   prtc_pkg::entry_type slot_ff [prtc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign valid = (count_ff != '0);
   assign full  = (count_ff == CNT_FULL);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> src/prtc_back.sv
// Back end: byte store, tick counter, alarm shadows and result register.
module prtc_back #(
   parameter int STORE_BYTES  = prtc_pkg::STORE_BYTES_DEF,
   parameter int COUNTER_BITS = prtc_pkg::COUNTER_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  prtc_pkg::cfg_type   cfg,
   input  logic                cfg_wr,
   input  logic                q_valid,
   input  prtc_pkg::entry_type q_entry,
   output logic                q_pop,
   output logic                back_busy,
   output logic                rsp_valid,
   output logic [7:0]          rsp_read_data,
   output logic                rsp_status,
   output logic                rsp_irq_level
);

   localparam int AW = $clog2(STORE_BYTES);
   localparam logic [16:0]   STORE_LIMIT = 17'(STORE_BYTES);
   localparam logic [AW-1:0] CLEAR_LAST  = AW'(STORE_BYTES - 1);

   // Shadow copies of the alarm bytes: control, event, irq mask, four value bytes
   localparam int SH_COUNT = 3 + prtc_pkg::ALARM_BYTES;
   localparam int SH_CTRL  = 0;
   localparam int SH_EVENT = 1;
   localparam int SH_IRQM  = 2;
   localparam int SH_VAL0  = 3;
   localparam logic [2:0] RELOAD_LAST = 3'(SH_COUNT);

   prtc_pkg::back_state_type state_ff, state_in;

   logic [7:0]    mem [STORE_BYTES];
   logic [7:0]    mem_q_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_wdata;

   logic [AW-1:0] clear_cnt_ff;
   logic [2:0]    rl_cnt_ff;
   logic          reload_pend_ff;

   prtc_pkg::entry_type op_ff;
   logic [COUNTER_BITS-1:0] counter_ff, snap_ff;

   logic [7:0]  sh_ff [SH_COUNT];
   logic [7:0]  sh_in [SH_COUNT];
   logic [16:0] sh_addr [SH_COUNT];
   logic        sh_ok [SH_COUNT];

   logic        do_check, enabled, due, alarm_hit;
   logic [31:0] secs;
   logic [7:0]  ev_new, win_byte, rd_byte;
   logic [47:0] win_bits;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_read_data_ff;
   logic        rsp_status_ff;
   logic        rsp_irq_ff;

   assign back_busy = (state_ff == prtc_pkg::BK_CLEAR) || (state_ff == prtc_pkg::BK_RELOAD) ||
                      reload_pend_ff;

   always_comb begin
      sh_addr[SH_CTRL]  = {1'b0, cfg.ctrl_addr};
      sh_addr[SH_EVENT] = {1'b0, cfg.event_addr};
      sh_addr[SH_IRQM]  = {1'b0, cfg.irqm_addr};
      for (int i = 0; i < prtc_pkg::ALARM_BYTES; i++) begin
         sh_addr[SH_VAL0 + i] = {1'b0, cfg.value_addr} + 17'(i);
      end
      for (int i = 0; i < SH_COUNT; i++) begin
         sh_ok[i] = (sh_addr[i] < STORE_LIMIT);
      end
   end

   // Alarm compare against whole seconds of the counter
   always_comb begin
      do_check = (op_ff.op == prtc_pkg::OP_TICK) ||
                 ((op_ff.op == prtc_pkg::OP_WRITE) && op_ff.alarm_check);
      enabled  = ((sh_ff[SH_CTRL] & cfg.enable_mask) != 8'h00);
      secs     = {sh_ff[SH_VAL0 + 3], sh_ff[SH_VAL0 + 2], sh_ff[SH_VAL0 + 1], sh_ff[SH_VAL0]};
      due      = (64'(secs) <= 64'(counter_ff >> 15));
      alarm_hit = (state_ff == prtc_pkg::BK_FINISH) && do_check && enabled && due &&
                  sh_ok[SH_EVENT];
      ev_new   = sh_ff[SH_EVENT] | cfg.event_bits;
   end

   // State machine and store port control
   always_comb begin
      state_in  = state_ff;
      q_pop     = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = clear_cnt_ff;
      mem_wdata = 8'h00;
      mem_raddr = q_entry.address[AW-1:0];
      case (state_ff)
         prtc_pkg::BK_CLEAR: begin
            mem_we = 1'b1;
            if (clear_cnt_ff == CLEAR_LAST) begin
               state_in = prtc_pkg::BK_RUN;
            end
         end
         prtc_pkg::BK_RELOAD: begin
            for (int i = 0; i < SH_COUNT; i++) begin
               if (rl_cnt_ff == 3'(i)) begin
                  mem_raddr = sh_addr[i][AW-1:0];
               end
            end
            if (rl_cnt_ff == RELOAD_LAST) begin
               state_in = prtc_pkg::BK_RUN;
            end
         end
         prtc_pkg::BK_RUN: begin
            if (reload_pend_ff) begin
               state_in = prtc_pkg::BK_RELOAD;
            end else if (q_valid) begin
               q_pop    = 1'b1;
               state_in = prtc_pkg::BK_FINISH;
               if (q_entry.op == prtc_pkg::OP_WRITE) begin
                  mem_we    = 1'b1;
                  mem_waddr = q_entry.address[AW-1:0];
                  mem_wdata = q_entry.write_data;
               end
            end
         end
         prtc_pkg::BK_FINISH: begin
            state_in = prtc_pkg::BK_RUN;
            if (alarm_hit) begin
               mem_we    = 1'b1;
               mem_waddr = sh_addr[SH_EVENT][AW-1:0];
               mem_wdata = ev_new;
            end
         end
         default: state_in = prtc_pkg::BK_RUN;
      endcase
   end

   // Keep shadows equal to the store bytes they mirror
   always_comb begin
      for (int i = 0; i < SH_COUNT; i++) begin
         sh_in[i] = sh_ff[i];
         if (q_pop && (q_entry.op == prtc_pkg::OP_WRITE) &&
             (sh_addr[i] == {1'b0, q_entry.address})) begin
            sh_in[i] = q_entry.write_data;
         end
         if (alarm_hit && (sh_addr[i] == sh_addr[SH_EVENT])) begin
            sh_in[i] = ev_new;
         end
         if ((state_ff == prtc_pkg::BK_RELOAD) && (rl_cnt_ff == 3'(i + 1))) begin
            sh_in[i] = sh_ok[i] ? mem_q_ff : 8'h00;
         end
      end
   end

   always_comb begin
      win_bits = 48'({snap_ff, 1'b0});
      case (op_ff.win_ofs)
         3'd0:    win_byte = win_bits[7:0];
         3'd1:    win_byte = win_bits[15:8];
         3'd2:    win_byte = win_bits[23:16];
         3'd3:    win_byte = win_bits[31:24];
         3'd4:    win_byte = win_bits[39:32];
         3'd5:    win_byte = win_bits[47:40];
         default: win_byte = 8'h00;
      endcase
      if (op_ff.op == prtc_pkg::OP_READ) begin
         rd_byte = op_ff.in_window ? win_byte : mem_q_ff;
      end else begin
         rd_byte = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prtc_pkg::BK_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff   <= '0;
         rl_cnt_ff      <= '0;
         reload_pend_ff <= 1'b0;
         counter_ff     <= '0;
         snap_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < SH_COUNT; i++) begin
            sh_ff[i] <= 8'h00;
         end
      end else begin
         if (state_ff == prtc_pkg::BK_CLEAR) begin
            clear_cnt_ff <= clear_cnt_ff + AW'(1);
         end
         rl_cnt_ff <= (state_ff == prtc_pkg::BK_RELOAD) ? rl_cnt_ff + 3'd1 : 3'd0;
         // A freshly cleared store leaves every shadow at zero, so no reload is owed
         if (cfg_wr) begin
            reload_pend_ff <= 1'b1;
         end else if ((state_ff == prtc_pkg::BK_CLEAR) && (state_in == prtc_pkg::BK_RUN)) begin
            reload_pend_ff <= 1'b0;
         end else if ((state_ff == prtc_pkg::BK_RUN) && (state_in == prtc_pkg::BK_RELOAD)) begin
            reload_pend_ff <= 1'b0;
         end
         if (q_pop && (q_entry.op == prtc_pkg::OP_TICK)) begin
            counter_ff <= counter_ff + COUNTER_BITS'(1);
         end
         if (q_pop && (q_entry.op == prtc_pkg::OP_READ) && q_entry.snap_take) begin
            snap_ff <= counter_ff;
         end
         rsp_valid_ff <= (state_ff == prtc_pkg::BK_FINISH);
         for (int i = 0; i < SH_COUNT; i++) begin
            sh_ff[i] <= sh_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         op_ff <= q_entry;
      end
      if (state_ff == prtc_pkg::BK_FINISH) begin
         rsp_read_data_ff <= rd_byte;
         rsp_status_ff    <= (op_ff.op == prtc_pkg::OP_REJECT);
         rsp_irq_ff       <= ((sh_in[SH_IRQM] & sh_in[SH_EVENT] & cfg.event_bits) != 8'h00);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_irq_level = rsp_irq_ff;

endmodule

>>> src/pmu_rtc_register_file.sv
// Top level of the RTC register file: config port, front end, queue and back end.
//
//   channel   | direction | handshake                         | payload
//   request   | in        | start, busy (taken: start & !busy) | req_kind .. req_write_data
//   result    | out       | rsp_valid, one cycle, no stall     | rsp_read_data, rsp_status,
//             |           |                                    | rsp_irq_level
//   config    | in        | APB psel/penable/pwrite, pready=1  | paddr, pwdata, prdata
//
// Each transaction passes through back-end states BK_RUN (store access) and BK_FINISH
// (alarm check and result), so the back end takes no new one before the last is through;
// the single store port sets this. An accepted request passes the queue slot and
// BK_FINISH before the registered rsp_valid rises. After reset the store is cleared one
// byte a cycle; busy stays high until all STORE_BYTES bytes (65536 by default) are cleared.
// After each config write busy stays high while alarm shadow bytes reload from the store.
// The receiver cannot stall; otherwise busy rises only when the two-entry queue is full.
module pmu_rtc_register_file #(
   parameter int STORE_BYTES  = prtc_pkg::STORE_BYTES_DEF,
   parameter int COUNTER_BITS = prtc_pkg::COUNTER_BITS_DEF,
   parameter int MAX_TRANSFER = prtc_pkg::MAX_TRANSFER_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_kind,
   input  logic [15:0]                        req_address,
   input  logic                               req_first_byte,
   input  logic [4:0]                         req_transfer_len,
   input  logic [7:0]                         req_write_data,
   output logic                               rsp_valid,
   output logic [7:0]                         rsp_read_data,
   output logic                               rsp_status,
   output logic                               rsp_irq_level,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [prtc_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   prtc_pkg::cfg_type   cfg;
   prtc_pkg::entry_type new_entry, head_entry;
   logic                cfg_wr, accept, q_valid, q_full, q_pop, back_busy;

   assign busy   = q_full || back_busy;
   assign accept = start && !busy;

   prtc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg),
      .cfg_wr  (cfg_wr)
   );

   prtc_front #(
      .STORE_BYTES  (STORE_BYTES),
      .MAX_TRANSFER (MAX_TRANSFER)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .accept           (accept),
      .req_kind         (req_kind),
      .req_address      (req_address),
      .req_first_byte   (req_first_byte),
      .req_transfer_len (req_transfer_len),
      .req_write_data   (req_write_data),
      .entry            (new_entry)
   );

   prtc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (new_entry),
      .pop        (q_pop),
      .valid      (q_valid),
      .full       (q_full),
      .head       (head_entry)
   );

   prtc_back #(
      .STORE_BYTES  (STORE_BYTES),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .cfg_wr        (cfg_wr),
      .q_valid       (q_valid),
      .q_entry       (head_entry),
      .q_pop         (q_pop),
      .back_busy     (back_busy),
      .rsp_valid     (rsp_valid),
      .rsp_read_data (rsp_read_data),
      .rsp_status    (rsp_status),
      .rsp_irq_level (rsp_irq_level)
   );

   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results closer than two cycles apart");

   a_reject_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_read_data == 8'h00))
      else $error("rejected transaction returned data");

   a_busy_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy)
      else $error("request port open before store clear");

endmodule
